// File: sv/vvm_pkg.sv
// ----------------------------------------------------------------------------
// vvm_pkg
// Shared types and constants for the VLAN to VNI mapping table.
// ----------------------------------------------------------------------------
`default_nettype none

package vvm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KIND_W = 3;
  localparam int VLAN_W = 12;
  localparam int VNI_W  = 24;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD         = 3'd0,
    KIND_REMOVE      = 3'd1,
    KIND_LOOKUP_VLAN = 3'd2,
    KIND_LOOKUP_VNI  = 3'd3,
    KIND_CLEAR       = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_VNI_OWNED = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [VLAN_W-1:0] vlan;
    logic [VNI_W-1:0]  vni;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/vvm_req_if.sv
// ----------------------------------------------------------------------------
// vvm_req_if
// Request channel: operation kind, VLAN and VNI with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vvm_req_if;
  logic                       valid;
  logic                       ready;
  logic [vvm_pkg::KIND_W-1:0] kind;
  logic [vvm_pkg::VLAN_W-1:0] vlan_id;
  logic [vvm_pkg::VNI_W-1:0]  vni;

  modport source (output valid, kind, vlan_id, vni, input ready);
  modport sink   (input valid, kind, vlan_id, vni, output ready);
endinterface

`default_nettype wire

// File: sv/vvm_rsp_if.sv
// ----------------------------------------------------------------------------
// vvm_rsp_if
// Response channel: status and found identifiers with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vvm_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [vvm_pkg::STAT_W-1:0] status;
  logic [vvm_pkg::VLAN_W-1:0] found_vlan;
  logic [vvm_pkg::VNI_W-1:0]  found_vni;

  modport source (output valid, status, found_vlan, found_vni, input ready);
  modport sink   (input valid, status, found_vlan, found_vni, output ready);
endinterface

`default_nettype wire

// File: sv/vlan_vni_mapping_table.sv
// ----------------------------------------------------------------------------
// vlan_vni_mapping_table
// Bounded one-to-one VLAN/VNI table held in a single-port entry RAM with
// per-entry valid flops. Every request scans the whole RAM, then commits.
// ----------------------------------------------------------------------------
// a request is accepted in ST_IDLE, read through every entry in ST_SCAN and
//   ST_DRAIN, committed in ST_DECIDE and held in the response register
// one request is in the block at a time; its pace is
//   set by the linear scan through the entry RAM, one read per cycle
// the response register frees the request side while a response waits
// reset clears the valid flops at once: the table is empty, no clearing pass
`default_nettype none

module vlan_vni_mapping_table (
  input  wire          clk,
  input  wire          rst,
  vvm_req_if.sink      req,
  vvm_rsp_if.source    rsp
);

  localparam int N     = vvm_pkg::TABLE_ENTRIES;
  localparam int IDX_W = vvm_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);

  vvm_pkg::state_t state, state_next;

  // latched request
  vvm_pkg::kind_t              r_kind;
  logic [vvm_pkg::VLAN_W-1:0]  r_vlan;
  logic [vvm_pkg::VNI_W-1:0]   r_vni;

  // entry store
  vvm_pkg::entry_t             mem [N];
  vvm_pkg::entry_t             rd_data;
  logic [N-1:0]                vld;

  logic [IDX_W-1:0]            cnt;
  logic                        p_vld;
  logic [IDX_W-1:0]            p_idx;
  logic                        p_vb;

  // scan results
  logic                        at_hit;
  logic [IDX_W-1:0]            at_idx;
  logic [vvm_pkg::VNI_W-1:0]   at_vni;
  logic                        own_hit;
  logic [IDX_W-1:0]            own_idx;
  logic [vvm_pkg::VLAN_W-1:0]  own_vlan;
  logic                        free_hit;
  logic [IDX_W-1:0]            free_idx;

  // response register
  logic                        out_valid;
  vvm_pkg::status_t            out_status;
  logic [vvm_pkg::VLAN_W-1:0]  out_vlan;
  logic [vvm_pkg::VNI_W-1:0]   out_vni;

  logic                        accept;
  logic                        issue;
  logic                        decide;

  // commit decisions
  vvm_pkg::status_t            d_status;
  logic [vvm_pkg::VLAN_W-1:0]  d_vlan;
  logic [vvm_pkg::VNI_W-1:0]   d_vni;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  vvm_pkg::entry_t             mem_wdata;
  logic                        vld_set;
  logic                        vld_clr;
  logic [IDX_W-1:0]            vld_idx;
  logic                        clr_all;

  logic                        m_vlan;
  logic                        m_vni;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vvm_pkg::ST_IDLE: begin
        if (req.valid) state_next = vvm_pkg::ST_SCAN;
      end
      vvm_pkg::ST_SCAN: begin
        if (cnt == LAST_IDX) state_next = vvm_pkg::ST_DRAIN;
      end
      vvm_pkg::ST_DRAIN: begin
        state_next = vvm_pkg::ST_DECIDE;
      end
      vvm_pkg::ST_DECIDE: begin
        if (!out_valid || rsp.ready) state_next = vvm_pkg::ST_IDLE;
      end
      default: begin
        state_next = vvm_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    issue     = 1'b0;
    decide    = 1'b0;
    case (state)
      vvm_pkg::ST_IDLE:   req.ready = 1'b1;
      vvm_pkg::ST_SCAN:   issue     = 1'b1;
      vvm_pkg::ST_DRAIN:  ;
      vvm_pkg::ST_DECIDE: decide    = !out_valid || rsp.ready;
      default:            ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vvm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_kind <= vvm_pkg::kind_t'(req.kind);
      r_vlan <= req.vlan_id;
      r_vni  <= req.vni;
    end
  end

  // scan address and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      p_vld <= 1'b0;
    end else begin
      p_vld <= issue;
      if (accept) begin
        cnt <= '0;
      end else if (issue && cnt != LAST_IDX) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[cnt];
      p_idx   <= cnt;
      p_vb    <= vld[cnt];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign m_vlan = p_vb && (rd_data.vlan == r_vlan);
  assign m_vni  = p_vb && (rd_data.vni == r_vni);

  // first match of each kind wins
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      at_hit   <= 1'b0;
      own_hit  <= 1'b0;
      free_hit <= 1'b0;
    end else if (p_vld) begin
      if (m_vlan && !at_hit) begin
        at_hit <= 1'b1;
        at_idx <= p_idx;
        at_vni <= rd_data.vni;
      end
      if (m_vni && !own_hit) begin
        own_hit  <= 1'b1;
        own_idx  <= p_idx;
        own_vlan <= rd_data.vlan;
      end
      if (!p_vb && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= p_idx;
      end
    end
  end

  // commit logic
  always_comb begin
    d_status  = vvm_pkg::STAT_OK;
    d_vlan    = '0;
    d_vni     = '0;
    mem_we    = 1'b0;
    mem_waddr = at_idx;
    mem_wdata = '{vlan: r_vlan, vni: r_vni};
    vld_set   = 1'b0;
    vld_clr   = 1'b0;
    vld_idx   = at_idx;
    clr_all   = 1'b0;
    case (r_kind)
      vvm_pkg::KIND_ADD: begin
        if (at_hit) begin
          if (at_vni == r_vni) begin
            d_status = vvm_pkg::STAT_OK;
          end else if (own_hit && own_idx != at_idx) begin
            d_status = vvm_pkg::STAT_VNI_OWNED;
          end else begin
            mem_we = decide;
          end
        end else if (own_hit) begin
          d_status = vvm_pkg::STAT_VNI_OWNED;
        end else if (!free_hit) begin
          d_status = vvm_pkg::STAT_FULL;
        end else begin
          mem_we    = decide;
          mem_waddr = free_idx;
          vld_set   = decide;
          vld_idx   = free_idx;
        end
      end
      vvm_pkg::KIND_REMOVE: begin
        if (at_hit) vld_clr = decide;
        else        d_status = vvm_pkg::STAT_NOT_FOUND;
      end
      vvm_pkg::KIND_LOOKUP_VLAN: begin
        if (at_hit) d_vni = at_vni;
        else        d_status = vvm_pkg::STAT_NOT_FOUND;
      end
      vvm_pkg::KIND_LOOKUP_VNI: begin
        // vni zero never matches a lookup
        if (own_hit && r_vni != '0) d_vlan = own_vlan;
        else                        d_status = vvm_pkg::STAT_NOT_FOUND;
      end
      vvm_pkg::KIND_CLEAR: begin
        clr_all = decide;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      vld <= '0;
    end else if (vld_set) begin
      vld[vld_idx] <= 1'b1;
    end else if (vld_clr) begin
      vld[vld_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (decide) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      out_status <= d_status;
      out_vlan   <= d_vlan;
      out_vni    <= d_vni;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found_vlan = out_vlan;
  assign rsp.found_vni  = out_vni;

`ifndef ASSERT_OFF
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == vvm_pkg::ST_SCAN && cnt == '0))
    else $error("request accept did not start a scan from entry zero");

  a_decide_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    decide |=> rsp.valid)
    else $error("commit did not load the response register");

  a_same_pair_same_entry: assert property (@(posedge clk) disable iff (rst)
    (state == vvm_pkg::ST_DECIDE && at_hit && at_vni == r_vni)
      |-> (own_hit && own_idx == at_idx))
    else $error("vlan match and vni match disagree on the entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clr_all |=> (vld == '0))
    else $error("clear left valid entries");

  a_miss_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != vvm_pkg::STAT_OK)
      |-> (rsp.found_vlan == '0 && rsp.found_vni == '0))
    else $error("non-ok response carries found identifiers");
`endif

endmodule

`default_nettype wire

// File: dv/vlan_vni_mapping_table_test.sv
// ----------------------------------------------------------------------------
// vlan_vni_mapping_table_test
// Self-checking bench for the VLAN/VNI mapping table. A scoreboard keeps its
// own copy of the table, predicts the response to every accepted request and
// compares the responses in order. Both channels idle at random, and the
// response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module vlan_vni_mapping_table_test;
  import vvm_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int RANDOM_TARGET    = 425;
  localparam int POOL_SIZE        = 96;
  localparam int PRESSURE_AT      = 150;
  localparam int PRESSURE_CYCLES  = 700;
  localparam int DRAIN_CYCLES     = TABLE_ENTRIES + 16;
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
  localparam logic [VLAN_W-1:0] VLAN_MAX = '1;
  localparam logic [VNI_W-1:0]  VNI_MAX  = '1;

  typedef struct {
    status_t           status;
    logic [VLAN_W-1:0] found_vlan;
    logic [VNI_W-1:0]  found_vni;
  } table_rsp_t;

  class table_scoreboard;
    bit                slot_valid [TABLE_ENTRIES];
    logic [VLAN_W-1:0] slot_vlan  [TABLE_ENTRIES];
    logic [VNI_W-1:0]  slot_vni   [TABLE_ENTRIES];
    table_rsp_t        expected_q [$];
    int                errors;
    int                checked;
    int                status_count [4];

    function int find_vlan(logic [VLAN_W-1:0] vlan);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot_valid[i] && slot_vlan[i] == vlan) return i;
      return -1;
    endfunction

    function int find_vni(logic [VNI_W-1:0] vni);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot_valid[i] && slot_vni[i] == vni) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (!slot_valid[i]) return i;
      return -1;
    endfunction

    // update the table copy and queue the response this request must give
    function void note_request(logic [KIND_W-1:0] kind, logic [VLAN_W-1:0] vlan,
                               logic [VNI_W-1:0] vni);
      table_rsp_t r;
      int         at;
      int         owner;
      int         slot;
      r.status     = STAT_OK;
      r.found_vlan = '0;
      r.found_vni  = '0;
      case (kind)
        KIND_ADD: begin
          at    = find_vlan(vlan);
          owner = find_vni(vni);
          if (at >= 0) begin
            if (slot_vni[at] != vni) begin
              if (owner >= 0 && owner != at) r.status = STAT_VNI_OWNED;
              else slot_vni[at] = vni;
            end
          end else if (owner >= 0) begin
            r.status = STAT_VNI_OWNED;
          end else begin
            slot = find_free();
            if (slot < 0) begin
              r.status = STAT_FULL;
            end else begin
              slot_valid[slot] = 1'b1;
              slot_vlan[slot]  = vlan;
              slot_vni[slot]   = vni;
            end
          end
        end
        KIND_REMOVE: begin
          at = find_vlan(vlan);
          if (at < 0) r.status = STAT_NOT_FOUND;
          else slot_valid[at] = 1'b0;
        end
        KIND_LOOKUP_VLAN: begin
          at = find_vlan(vlan);
          if (at < 0) r.status = STAT_NOT_FOUND;
          else r.found_vni = slot_vni[at];
        end
        KIND_LOOKUP_VNI: begin
          // vni zero never matches
          at = (vni == '0) ? -1 : find_vni(vni);
          if (at < 0) r.status = STAT_NOT_FOUND;
          else r.found_vlan = slot_vlan[at];
        end
        KIND_CLEAR: begin
          for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
        end
        default: ;
      endcase
      status_count[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_response(logic [STAT_W-1:0] status, logic [VLAN_W-1:0] found_vlan,
                                 logic [VNI_W-1:0] found_vni);
      table_rsp_t r;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: response with none outstanding: status %0d vlan %0h vni %0h",
                 $time, status, found_vlan, found_vni);
        return;
      end
      r = expected_q.pop_front();
      if (status !== r.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
      end
      if (found_vlan !== r.found_vlan) begin
        errors++;
        $display("%0t: found_vlan expected %0h actual %0h", $time, r.found_vlan, found_vlan);
      end
      if (found_vni !== r.found_vni) begin
        errors++;
        $display("%0t: found_vni expected %0h actual %0h", $time, r.found_vni, found_vni);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  vvm_req_if req_ch ();
  vvm_rsp_if rsp_ch ();

  vlan_vni_mapping_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  table_scoreboard   sb = new();
  logic [VLAN_W-1:0] vlan_pool [POOL_SIZE];
  logic [VNI_W-1:0]  vni_pool  [POOL_SIZE];
  bit                sender_idle   = 1'b1;
  bit                receiver_idle = 1'b1;
  bit                pressure_done = 1'b0;
  int                requests_sent = 0;
  int                cycle_count   = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [VLAN_W-1:0] vlan,
                              input logic [VNI_W-1:0] vni);
    int gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.kind    = kind;
    req_ch.vlan_id = vlan;
    req_ch.vni     = vni;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(kind, vlan, vni);
    requests_sent++;
  endtask

  function automatic logic [VLAN_W-1:0] pick_vlan();
    if ($urandom_range(0, 3) != 0) return vlan_pool[$urandom_range(0, POOL_SIZE - 1)];
    return VLAN_W'($urandom);
  endfunction

  function automatic logic [VNI_W-1:0] pick_vni();
    if ($urandom_range(0, 3) != 0) return vni_pool[$urandom_range(0, POOL_SIZE - 1)];
    return VNI_W'($urandom);
  endfunction

  // only adds, so the table fills and the full status shows up
  task automatic fill_burst();
    int start;
    int shift;
    start = $urandom_range(0, POOL_SIZE - 1);
    shift = ($urandom_range(0, 2) == 0) ? $urandom_range(1, POOL_SIZE - 1) : 0;
    for (int k = 0; k < 80; k++)
      send_request(KIND_ADD, vlan_pool[(start + k) % POOL_SIZE],
                   vni_pool[(start + k + shift) % POOL_SIZE]);
  endtask

  task automatic mixed_request();
    int                pick;
    logic [KIND_W-1:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 35)      kind = KIND_ADD;
    else if (pick < 50) kind = KIND_REMOVE;
    else if (pick < 70) kind = KIND_LOOKUP_VLAN;
    else if (pick < 93) kind = KIND_LOOKUP_VNI;
    else if (pick < 94) kind = KIND_CLEAR;
    else kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    send_request(kind, pick_vlan(), pick_vni());
  endtask

  // response side: random stalls, and one long hold-off to back up the block
  initial begin : response_side
    int stall;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (sb.checked == PRESSURE_AT && !pressure_done) begin
        rsp_ch.ready = 1'b0;
        for (int c = 0; c < PRESSURE_CYCLES; c++) @(negedge clk);
        pressure_done = 1'b1;
      end
      stall = receiver_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      sb.check_response(rsp_ch.status, rsp_ch.found_vlan, rsp_ch.found_vni);
      if (sb.checked % 40 == 0) receiver_idle = ($urandom_range(0, 2) != 0);
    end
  end

  initial begin : request_side
    int mode;
    req_ch.valid   = 1'b0;
    req_ch.kind    = KIND_ADD;
    req_ch.vlan_id = '0;
    req_ch.vni     = '0;

    // distinct pool values spread over the whole range, extremes included
    for (int i = 0; i < POOL_SIZE; i++) begin
      vlan_pool[i] = VLAN_W'(i * 42 + $urandom_range(0, 41));
      vni_pool[i]  = VNI_W'(i * 174762 + $urandom_range(0, 174761));
    end
    vlan_pool[0] = '0;
    vlan_pool[POOL_SIZE - 1] = VLAN_MAX;
    vni_pool[0] = '0;
    vni_pool[POOL_SIZE - 1] = VNI_MAX;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, zero and all-ones ids, conflicts, update, removal, spare kinds, clear
    send_request(KIND_LOOKUP_VLAN, '0, '0);
    send_request(KIND_LOOKUP_VNI, '0, '0);
    send_request(KIND_REMOVE, VLAN_MAX, '0);
    send_request(KIND_ADD, '0, '0);
    send_request(KIND_LOOKUP_VLAN, '0, VNI_MAX);
    send_request(KIND_LOOKUP_VNI, '0, '0);
    send_request(KIND_ADD, VLAN_MAX, VNI_MAX);
    send_request(KIND_LOOKUP_VNI, '0, VNI_MAX);
    send_request(KIND_ADD, VLAN_MAX, VNI_MAX);
    send_request(KIND_ADD, 12'h005, VNI_MAX);
    send_request(KIND_ADD, VLAN_MAX, '0);
    send_request(KIND_ADD, VLAN_MAX, 24'h123456);
    send_request(KIND_LOOKUP_VLAN, VLAN_MAX, '0);
    send_request(KIND_LOOKUP_VNI, '0, 24'h123456);
    send_request(KIND_LOOKUP_VNI, '0, VNI_MAX);
    send_request(KIND_REMOVE, '0, VNI_MAX);
    send_request(KIND_REMOVE, '0, '0);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      send_request(KIND_W'(k), VLAN_MAX, VNI_MAX);
    send_request(KIND_CLEAR, VLAN_MAX, VNI_MAX);
    send_request(KIND_LOOKUP_VLAN, VLAN_MAX, '0);
    send_request(KIND_ADD, VLAN_MAX, 24'h123456);

    while (requests_sent < RANDOM_TARGET) begin
      mode = $urandom_range(0, 9);
      sender_idle = ($urandom_range(0, 3) != 0);
      case (mode)
        0, 1: fill_burst();
        7, 8: begin
          repeat (10)
            send_request(KIND_W'($urandom_range(0, 7)), VLAN_W'($urandom), VNI_W'($urandom));
        end
        9: send_request(KIND_CLEAR, pick_vlan(), pick_vni());
        default: repeat (30) mixed_request();
      endcase
    end
    @(negedge clk);
    req_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests checked over %0d cycles, one long response hold-off",
             sb.checked, cycle_count);
    $display("responses ok %0d, vni owned %0d, not found %0d, table full %0d",
             sb.status_count[STAT_OK], sb.status_count[STAT_VNI_OWNED],
             sb.status_count[STAT_NOT_FOUND], sb.status_count[STAT_FULL]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
